/* rtl/core/fbc_pkg.sv */
// Shared types and constants for the footswitch bypass controller.
`timescale 1ns / 1ps
`default_nettype none

package fbc_pkg;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LONGPRESS = 2'd0,
    REG_DEBOUNCE  = 2'd1,
    REG_AUDIO_CUT = 2'd2,
    REG_UNUSED    = 2'd3
  } cfg_reg_t;

  localparam logic [CFG_W-1:0] LONGPRESS_RST = 16'd500;
  localparam logic [CFG_W-1:0] DEBOUNCE_RST  = 16'd20;
  localparam logic [CFG_W-1:0] AUDIO_CUT_RST = 16'd10;

  // LED word layout: bit 0 main, bit 1 temp
  localparam logic [1:0] LED_OFF  = 2'b00;
  localparam logic [1:0] LED_MAIN = 2'b01;
  localparam logic [1:0] LED_TEMP = 2'b10;

  typedef struct packed {
    logic       last_sample;
    logic       press_active;
    logic       long_held;
    logic       effect_on;
    logic       disengage_armed;
    logic       relay;
    logic [1:0] leds;
    logic [1:0] pending_leds;
  } flags_t;

  typedef struct packed {
    logic [CFG_W-1:0] longpress_ticks;
    logic [CFG_W-1:0] debounce_ticks;
    logic [CFG_W-1:0] audio_cut_ticks;
  } cfg_t;

endpackage

`default_nettype wire

/* rtl/core/fbc_cfg.sv */
// Configuration register bank for the footswitch bypass controller.
`timescale 1ns / 1ps
`default_nettype none

module fbc_cfg
  import fbc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  output cfg_t                      cfg
);

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.longpress_ticks <= LONGPRESS_RST;
      cfg_r.debounce_ticks  <= DEBOUNCE_RST;
      cfg_r.audio_cut_ticks <= AUDIO_CUT_RST;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_LONGPRESS: cfg_r.longpress_ticks <= cfg_wdata;
        REG_DEBOUNCE:  cfg_r.debounce_ticks  <= cfg_wdata;
        REG_AUDIO_CUT: cfg_r.audio_cut_ticks <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/core/fbc_step.sv */
// Next-state logic for one footswitch sample: debounce, press handling, audio cut.
`timescale 1ns / 1ps
`default_nettype none

module fbc_step
  import fbc_pkg::*;
#(
  parameter int CW = 16
) (
  input  wire logic          sample,
  input  wire cfg_t          cfg,
  input  wire flags_t        flags,
  input  wire logic [CW-1:0] stable_cnt,
  input  wire logic [CW-1:0] held_cnt,
  input  wire logic [CW-1:0] cut_cnt,
  output flags_t             flags_nxt,
  output logic [CW-1:0]      stable_cnt_nxt,
  output logic [CW-1:0]      held_cnt_nxt,
  output logic [CW-1:0]      cut_cnt_nxt
);

  localparam int CMP_W = (CW > CFG_W) ? CW : CFG_W;
  localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};

  logic [CW-1:0] cut_len;
  logic          rc;
  logic          rc_on;
  logic          rc_temp;

  // Clamp the cut length to what the counter can hold
  assign cut_len = (CMP_W'(cfg.audio_cut_ticks) > CMP_W'(CNT_MAX)) ?
                   CNT_MAX : CW'(cfg.audio_cut_ticks);

  always_comb begin
    flags_nxt      = flags;
    stable_cnt_nxt = stable_cnt;
    held_cnt_nxt   = held_cnt;
    cut_cnt_nxt    = cut_cnt;
    rc             = 1'b0;
    rc_on          = 1'b0;
    rc_temp        = 1'b0;

    if (cut_cnt != '0) begin
      // Cut running: ignore the sample, release the deferred LEDs at the end
      cut_cnt_nxt = cut_cnt - CW'(1);
      if (cut_cnt == CW'(1)) begin
        flags_nxt.leds = flags.pending_leds;
      end
    end else begin
      if (sample != flags.last_sample) begin
        stable_cnt_nxt = '0;
      end else if (stable_cnt != CNT_MAX) begin
        stable_cnt_nxt = stable_cnt + CW'(1);
      end
      flags_nxt.last_sample = sample;

      if (CMP_W'(stable_cnt_nxt) > CMP_W'(cfg.debounce_ticks)) begin
        if (sample) begin
          if (!flags.press_active) begin
            flags_nxt.press_active = 1'b1;
            held_cnt_nxt           = '0;
            flags_nxt.long_held    = 1'b0;
            if (!flags.effect_on) begin
              flags_nxt.effect_on       = 1'b1;
              flags_nxt.disengage_armed = 1'b0;
              rc    = 1'b1;
              rc_on = 1'b1;
            end else begin
              flags_nxt.disengage_armed = 1'b1;
            end
          end else begin
            if (held_cnt != CNT_MAX) begin
              held_cnt_nxt = held_cnt + CW'(1);
            end
            if (!flags.long_held &&
                CMP_W'(held_cnt_nxt) >= CMP_W'(cfg.longpress_ticks)) begin
              flags_nxt.long_held = 1'b1;
              rc      = 1'b1;
              rc_on   = 1'b1;
              rc_temp = 1'b1;
            end
          end
        end else if (flags.press_active) begin
          flags_nxt.press_active = 1'b0;
          if (flags.long_held) begin
            flags_nxt.long_held = 1'b0;
            flags_nxt.effect_on = 1'b0;
            rc = 1'b1;
          end else if (flags.effect_on && flags.disengage_armed) begin
            flags_nxt.effect_on = 1'b0;
            rc = 1'b1;
          end
        end
      end

      // Relay change: set relay, stage LEDs, start the cut
      if (rc) begin
        flags_nxt.relay        = rc_on;
        flags_nxt.pending_leds = rc_on ? (rc_temp ? LED_TEMP : LED_MAIN) : LED_OFF;
        cut_cnt_nxt            = cut_len;
        if (cut_len == '0) begin
          flags_nxt.leds = flags_nxt.pending_leds;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/footswitch_bypass_controller.sv */
// Top level of the footswitch bypass controller: state, result register, ports.
`timescale 1ns / 1ps
`default_nettype none

// Takes one footswitch sample per transfer and returns one result per sample,
// showing relay, LEDs and cut status after that sample. The block accepts a
// new sample every cycle while in_stall is low; a result appears in the cycle
// after its sample is taken, held in a single result register. in_stall is
// high only while that register is full and the far side stalls it. All
// counters are COUNT_WIDTH bits and saturate; the configuration registers are
// 16 bits wide and reset to 500, 20 and 10 ticks (longpress, debounce, audio
// cut). Write configuration only while no result is outstanding.
module footswitch_bypass_controller
  import fbc_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_switch_pressed,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic                      out_relay_engaged,
  output logic                      out_main_led,
  output logic                      out_temp_led,
  output logic                      out_cut_active,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  cfg_t                   cfg;
  flags_t                 flags_r;
  flags_t                 flags_nxt;
  logic [COUNT_WIDTH-1:0] stable_cnt_r;
  logic [COUNT_WIDTH-1:0] stable_cnt_nxt;
  logic [COUNT_WIDTH-1:0] held_cnt_r;
  logic [COUNT_WIDTH-1:0] held_cnt_nxt;
  logic [COUNT_WIDTH-1:0] cut_cnt_r;
  logic [COUNT_WIDTH-1:0] cut_cnt_nxt;
  logic                   out_valid_r;
  logic                   relay_out_r;
  logic                   main_led_r;
  logic                   temp_led_r;
  logic                   cut_active_r;
  logic                   in_take;

  fbc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  fbc_step #(
    .CW (COUNT_WIDTH)
  ) u_step (
    .sample         (in_switch_pressed),
    .cfg            (cfg),
    .flags          (flags_r),
    .stable_cnt     (stable_cnt_r),
    .held_cnt       (held_cnt_r),
    .cut_cnt        (cut_cnt_r),
    .flags_nxt      (flags_nxt),
    .stable_cnt_nxt (stable_cnt_nxt),
    .held_cnt_nxt   (held_cnt_nxt),
    .cut_cnt_nxt    (cut_cnt_nxt)
  );

  // Hold off input only while the result register cannot drain
  assign in_stall = out_valid_r && out_stall;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r      <= '0;
      stable_cnt_r <= '0;
      held_cnt_r   <= '0;
      cut_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_take) begin
        flags_r      <= flags_nxt;
        stable_cnt_r <= stable_cnt_nxt;
        held_cnt_r   <= held_cnt_nxt;
        cut_cnt_r    <= cut_cnt_nxt;
        out_valid_r  <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      relay_out_r  <= flags_nxt.relay;
      main_led_r   <= flags_nxt.leds[0];
      temp_led_r   <= flags_nxt.leds[1];
      cut_active_r <= (cut_cnt_nxt != '0);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_relay_engaged = relay_out_r;
  assign out_main_led      = main_led_r;
  assign out_temp_led      = temp_led_r;
  assign out_cut_active    = cut_active_r;

endmodule

`default_nettype wire

/* tb/tb_footswitch_bypass_controller.sv */
// Self-checking testbench for the footswitch bypass controller: random press runs against a predictor.
`timescale 1ns / 1ps

module tb_footswitch_bypass_controller;
  import fbc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int SHOW_MAX = 10;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic relay;
    logic main_led;
    logic temp_led;
    logic cut;
  } bypass_view_t;

  // Tracks the controller state tick by tick and holds the views still owed by the block.
  class bypass_scoreboard;
    logic [CFG_W-1:0] hold_limit   = LONGPRESS_RST;
    logic [CFG_W-1:0] settle_limit = DEBOUNCE_RST;
    logic [CFG_W-1:0] mute_length  = AUDIO_CUT_RST;

    bit               level_seen;
    logic [CFG_W-1:0] settle_run   = '0;
    bit               pressing;
    logic [CFG_W-1:0] hold_run     = '0;
    bit               in_longpress;
    bit               engaged;
    bit               armed;
    logic [CFG_W-1:0] mute_left    = '0;
    bit               relay_on;
    logic [1:0]       led_word     = LED_OFF;
    logic [1:0]       led_next     = LED_OFF;

    bypass_view_t     owed_views[$];
    int               errors;

    function void write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_LONGPRESS: hold_limit = val;
        REG_DEBOUNCE:  settle_limit = val;
        REG_AUDIO_CUT: mute_length = val;
        default: ;
      endcase
    endfunction

    function void switch_relay(bit on, logic [1:0] leds);
      relay_on  = on;
      led_next  = leds;
      mute_left = mute_length;
      if (mute_left == 0) led_word = led_next;
    endfunction

    function void note_sample(bit level);
      if (mute_left != 0) begin
        // input is ignored while the audio is cut
        mute_left--;
        if (mute_left == 0) led_word = led_next;
      end else begin
        if (level != level_seen) settle_run = '0;
        else if (settle_run != '1) settle_run++;
        level_seen = level;
        if (settle_run > settle_limit) begin
          if (level) begin
            if (!pressing) begin
              pressing     = 1'b1;
              hold_run     = '0;
              in_longpress = 1'b0;
              if (!engaged) begin
                engaged = 1'b1;
                armed   = 1'b0;
                switch_relay(1'b1, LED_MAIN);
              end else begin
                armed = 1'b1;
              end
            end else begin
              if (hold_run != '1) hold_run++;
              if (!in_longpress && hold_run >= hold_limit) begin
                in_longpress = 1'b1;
                switch_relay(1'b1, LED_TEMP);
              end
            end
          end else if (pressing) begin
            pressing = 1'b0;
            if (in_longpress) begin
              in_longpress = 1'b0;
              engaged      = 1'b0;
              switch_relay(1'b0, LED_OFF);
            end else if (engaged && armed) begin
              engaged = 1'b0;
              switch_relay(1'b0, LED_OFF);
            end
          end
        end
      end
      owed_views.push_back('{relay_on, led_word[0], led_word[1], mute_left != 0});
    endfunction

    function void flag_field(string field, logic want, logic got);
      errors++;
      if (errors <= SHOW_MAX)
        $display("mismatch on %s: expected %0b, got %0b", field, want, got);
    endfunction

    function void check_result(bypass_view_t got);
      bypass_view_t want;
      if (owed_views.size() == 0) begin
        errors++;
        if (errors <= SHOW_MAX) $display("result with nothing outstanding: %b", got);
        return;
      end
      want = owed_views.pop_front();
      if (got.relay !== want.relay) flag_field("relay_engaged", want.relay, got.relay);
      if (got.main_led !== want.main_led) flag_field("main_led", want.main_led, got.main_led);
      if (got.temp_led !== want.temp_led) flag_field("temp_led", want.temp_led, got.temp_led);
      if (got.cut !== want.cut) flag_field("cut_active", want.cut, got.cut);
    endfunction

    function int pending();
      return owed_views.size();
    endfunction
  endclass

  logic               clk;
  logic               rst_n             = 1'b0;
  logic               in_valid          = 1'b0;
  logic               in_switch_pressed = 1'b0;
  logic               out_stall         = 1'b0;
  logic               cfg_valid         = 1'b0;
  cfg_reg_t           cfg_index         = REG_LONGPRESS;
  logic [CFG_W-1:0]   cfg_wdata         = '0;
  logic               in_stall;
  logic               out_valid;
  logic               out_relay_engaged;
  logic               out_main_led;
  logic               out_temp_led;
  logic               out_cut_active;
  logic               cfg_ready;

  bypass_scoreboard   sb;
  int unsigned        cycles = 0;
  int                 gap_pct = 0;
  int                 stall_pct = 0;
  int                 sent = 0;
  int                 cur_lp = int'(LONGPRESS_RST);
  int                 cur_db = int'(DEBOUNCE_RST);
  int                 cur_cut = int'(AUDIO_CUT_RST);

  footswitch_bypass_controller dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_switch_pressed (in_switch_pressed),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_relay_engaged (out_relay_engaged),
    .out_main_led      (out_main_led),
    .out_temp_led      (out_temp_led),
    .out_cut_active    (out_cut_active),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Observe transfers on all three channels at the edge where they happen.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        sb.check_result('{out_relay_engaged, out_main_led, out_temp_led, out_cut_active});
      if (in_valid && !in_stall) sb.note_sample(in_switch_pressed);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_wdata);
    end
  end

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_SENDER:   begin gap_pct = 51; stall_pct = 0;  end
      IDLE_RECEIVER: begin gap_pct = 0;  stall_pct = 51; end
      IDLE_BOTH:     begin gap_pct = 19; stall_pct = 19; end
      default:       begin gap_pct = 0;  stall_pct = 0;  end
    endcase
  endtask

  task automatic send_tick(input bit level);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_switch_pressed <= level;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  task automatic play_run(input bit level, input int n);
    repeat (n) send_tick(level);
  endtask

  task automatic play_pattern(input logic [31:0] pat, input int n);
    for (int i = n - 1; i >= 0; i--) send_tick(pat[i]);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(input int lp, input int db, input int cut, input bit poke_unused);
    drain();
    write_reg(REG_LONGPRESS, CFG_W'(lp));
    write_reg(REG_DEBOUNCE, CFG_W'(db));
    write_reg(REG_AUDIO_CUT, CFG_W'(cut));
    if (poke_unused) write_reg(REG_UNUSED, CFG_W'($urandom));
    cfg_valid <= 1'b0;
    cur_lp  = lp;
    cur_db  = db;
    cur_cut = cut;
  endtask

  // One level held for a while, sometimes led in by contact bounce.
  task automatic play_segment(input bit level, input int room);
    int len;
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) begin
        send_tick(!level);
        send_tick(level);
      end
    case ($urandom_range(0, 3))
      0: len = $urandom_range(1, cur_db + 1);
      1: len = cur_db + 1 + $urandom_range(0, 2);
      2: len = cur_db + cur_lp + 1 + $urandom_range(0, 3);
      default: len = $urandom_range(1, cur_db + cur_lp + cur_cut + 6);
    endcase
    if (len > room) len = room;
    if (len < 1) len = 1;
    play_run(level, len);
  endtask

  task automatic run_random(input int budget);
    int start;
    bit level;
    start = sent;
    level = 1'b1;
    while (sent - start < budget) begin
      play_segment(level, budget - (sent - start));
      if ($urandom_range(0, 99) < 85) level = !level;
    end
  endtask

  task automatic run_phase(input int lp, input int db, input int cut, input bit poke_unused,
                           input idle_mode_t mode, input int budget);
    configure(lp, db, cut, poke_unused);
    set_idling(mode);
    run_random(budget);
  endtask

  initial begin
    sb = new;
    set_idling(IDLE_NONE);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings first, before any register write
    run_random(60);

    // zero debounce and cut: click, re-click, then a held press that goes long
    configure(2, 0, 0, 1'b0);
    play_pattern(32'b00_1110_0110_0111_1100, 18);
    // zero longpress with a short cut: input ignored while cut runs
    configure(0, 0, 2, 1'b1);
    play_pattern(32'b111_1110_0000, 11);

    run_phase(3, 0, 0, 1'b0, IDLE_SENDER, 80);
    run_phase(0, 1, 2, 1'b0, IDLE_RECEIVER, 80);
    run_phase(1, 2, 1, 1'b0, IDLE_BOTH, 80);
    run_phase(6, 1, 4, 1'b0, IDLE_NONE, 80);
    run_phase(10, 3, 0, 1'b0, IDLE_SENDER, 80);
    run_phase(4, 0, 3, 1'b1, IDLE_RECEIVER, 80);
    run_phase(2, 65535, 5, 1'b0, IDLE_BOTH, 40);
    run_phase(8, 2, 2, 1'b0, IDLE_BOTH, 80);

    drain();
    repeat (4) @(posedge clk);
    sb.errors += sb.pending();
    if (sb.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
